// ===== design/sphere_segment_newton_intersect_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment/sphere Newton intersect block
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SPHERE_SEGMENT_NEWTON_INTERSECT_TOP_DEFINES_SVH
`define SPHERE_SEGMENT_NEWTON_INTERSECT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SSNI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ssni check failed");
`define SSNI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ssni check failed");
`else
`define SSNI_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SSNI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/ssni_pkg.sv =====
// ----------------------------------------------------------------------------
// ssni_pkg
// Shared widths, register indexes, divider types, saturating helpers and a magnitude helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ssni_pkg;

	localparam int CRD_W     = 32;
	localparam int VAL_W     = 64;
	localparam int OP_W      = 34;
	localparam int PROD_W    = 68;
	localparam int NUM_W     = 98;
	localparam int DEN_W     = 64;
	localparam int DIV_CELLS = 2;
	localparam int DIV_STEPS = NUM_W / DIV_CELLS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 32;

	localparam logic [CFG_AW-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_CENTER_Z    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_RADIUS      = 3'd3;
	localparam logic [CFG_AW-1:0] REG_INSIDE_MODE = 3'd4;

	localparam logic [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic             go;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [VAL_W-1:0] sat_prod(input logic [PROD_W-1:0] x);
		logic [4:0] top;
		top = x[PROD_W-1:VAL_W-1];
		if (top == 5'h00 || top == 5'h1F)
			return x[VAL_W-1:0];
		return x[PROD_W-1] ? VAL_MIN : VAL_MAX;
	endfunction

	function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W:0] sum;
		sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (sum[VAL_W] != sum[VAL_W-1])
			return sum[VAL_W] ? VAL_MIN : VAL_MAX;
		return sum[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] sat_neg(input logic [VAL_W-1:0] x);
		if (x == VAL_MIN)
			return VAL_MAX;
		return (~x) + 64'd1;
	endfunction

	function automatic logic [VAL_W-1:0] mag64(input logic [VAL_W-1:0] x);
		return x[VAL_W-1] ? ((~x) + 64'd1) : x;
	endfunction

endpackage

`default_nettype wire

// ===== design/sphere_segment_newton_intersect_top.sv =====
// ----------------------------------------------------------------------------
// sphere_segment_newton_intersect_top
// Newton search along a segment for the crossing of a sphere surface.
// ----------------------------------------------------------------------------
// channel   handshake            words
// input     start / busy         in_x in_y in_z out_x out_y out_z
// result    done (strobe)        hit_x hit_y hit_z converged iterations
// config    cfg_we               cfg_addr cfg_wdata
//
// One item at a time; busy stays high until the cycle of its result strobe.
// Each Newton update works out value, slope and flat test on the shared
// multiplier. A normal step then takes, per coordinate, the numerator
// products and the divider cell row (49 steps of 2 bits over a 98-bit
// numerator, then hand back). A flat step multiplies by a reciprocal of
// ten instead. Up to MAX_ITER updates, then the exit state.
// Reset clears control state and loads the register reset values.
// The result strobe is high for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_segment_newton_intersect_top_defines.svh"

module sphere_segment_newton_intersect_top #(
	parameter int MAX_ITER  = 10,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [31:0]                  in_x,
	input  wire logic signed [31:0]                  in_y,
	input  wire logic signed [31:0]                  in_z,
	input  wire logic signed [31:0]                  out_x,
	input  wire logic signed [31:0]                  out_y,
	input  wire logic signed [31:0]                  out_z,
	input  wire logic                                cfg_we,
	input  wire logic        [ssni_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic        [ssni_pkg::CFG_DW-1:0]  cfg_wdata,
	output logic                                     done,
	output logic signed      [31:0]                  hit_x,
	output logic signed      [31:0]                  hit_y,
	output logic signed      [31:0]                  hit_z,
	output logic                                     converged,
	output logic             [6:0]                   iterations
);

	localparam logic [63:0] ONE_V = 64'd1 << (2 * FRAC_BITS);
	localparam logic [63:0] TOL_V = (ONE_V + 64'd9999) / 64'd10000;
	localparam logic signed [33:0] K_1E8 = 34'sd100000000;
	localparam logic signed [33:0] K_R10 = 34'sd3435973837;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_NUM  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]               state_q;
	logic [3:0]               ms_q;
	logic [1:0]               coord_q;
	logic [6:0]               it_q;
	logic                     conv_q;
	logic                     done_q;

	logic signed [31:0]       center_q [3];
	logic [30:0]              radius_q;
	logic                     inside_q;

	logic signed [31:0]       p_q [3];
	logic signed [32:0]       s_q [3];
	logic [63:0]              val_q;
	logic [63:0]              dot_q;
	logic [63:0]              wlo_q;
	logic [64:0]              nlo_q;
	logic                     flat_q;
	logic signed [67:0]       prod_s1;

	logic signed [31:0]       hit_q [3];
	logic                     conv_out_q;
	logic [6:0]               iter_out_q;

	logic signed [32:0]       d [3];
	logic signed [33:0]       ma;
	logic signed [33:0]       mb;
	logic [63:0]              mv;
	logic [63:0]              md;
	logic [32:0]              abs_s;
	logic                     conv_now;
	logic [64:0]              wide;
	logic                     flat_now;
	logic [63:0]              val_rr;
	logic [63:0]              dot_x2;

	ssni_pkg::div_req_t       div_req;
	ssni_pkg::div_stat_t      div_stat;
	logic [ssni_pkg::NUM_W-1:0] quo;

	logic                     flat_fire;
	logic                     step_done;
	logic [ssni_pkg::NUM_W-1:0] qv;
	logic                     q_big;
	logic                     q_neg;
	logic [63:0]              q_mag;
	logic signed [65:0]       corr;
	logic signed [65:0]       diff;
	logic signed [31:0]       p_new;
	logic                     last_coord;
	logic                     last_iter;

	always_comb begin
		for (int i = 0; i < 3; i++)
			d[i] = 33'(p_q[i]) - 33'(center_q[i]);
		mv       = ssni_pkg::mag64(val_q);
		md       = ssni_pkg::mag64(dot_q);
		abs_s    = s_q[coord_q][32] ? 33'(-s_q[coord_q]) : 33'(s_q[coord_q]);
		conv_now = (mv < TOL_V);
		wide     = {1'b0, wlo_q} + {1'b0, prod_s1[31:0], 32'd0};
		flat_now = (md[63:37] == '0) && (wide < {1'b0, mv});
		val_rr   = ssni_pkg::sat_add(val_q, ~prod_s1[63:0] + 64'd1);
		dot_x2   = ssni_pkg::sat_add(dot_q, dot_q);
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_EVAL: begin
				case (ms_q)
					4'd0: begin ma = 34'(d[0]); mb = 34'(d[0]); end
					4'd1: begin ma = 34'(d[1]); mb = 34'(d[1]); end
					4'd2: begin ma = 34'(d[2]); mb = 34'(d[2]); end
					4'd3: begin ma = {3'b0, radius_q}; mb = {3'b0, radius_q}; end
					4'd4: begin ma = 34'(d[0]); mb = 34'(s_q[0]); end
					4'd5: begin ma = 34'(d[1]); mb = 34'(s_q[1]); end
					4'd6: begin ma = 34'(d[2]); mb = 34'(s_q[2]); end
					4'd9: begin ma = {2'b0, md[31:0]}; mb = K_1E8; end
					4'd10: begin ma = {29'b0, md[36:32]}; mb = K_1E8; end
					default: begin ma = '0; mb = '0; end
				endcase
			end
			S_NUM: begin
				ma = {1'b0, abs_s};
				mb = flat_q ? K_R10
					: ((ms_q == 4'd0) ? {2'b0, mv[31:0]} : {2'b0, mv[63:32]});
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_comb begin
		div_req.go  = (state_q == S_NUM) && !flat_q && (ms_q == 4'd2);
		div_req.num = ssni_pkg::NUM_W'(nlo_q) + (ssni_pkg::NUM_W'(prod_s1[64:0]) << 32);
		div_req.den = md;
	end

	ssni_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quo    (quo)
	);

	always_comb begin
		flat_fire = (state_q == S_NUM) && flat_q && (ms_q == 4'd1);
		step_done = flat_fire || ((state_q == S_DIV) && div_stat.done);
		qv    = flat_q ? ssni_pkg::NUM_W'(prod_s1[63:35]) : quo;
		q_big = |qv[ssni_pkg::NUM_W-1:63];
		q_neg = flat_q ? s_q[coord_q][32]
			: (s_q[coord_q][32] ^ val_q[63] ^ dot_q[63]);
		q_mag = q_big ? ssni_pkg::VAL_MIN : {1'b0, qv[62:0]};
		corr  = q_neg ? -$signed({2'b0, q_mag}) : $signed({2'b0, q_mag});
		diff  = 66'(p_q[coord_q]) - corr;
		if (diff[65:31] == '0 || diff[65:31] == '1)
			p_new = diff[31:0];
		else
			p_new = diff[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		last_coord = (coord_q == 2'd2);
		last_iter  = (it_q + 7'd1 == 7'(MAX_ITER));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ms_q        <= '0;
			coord_q     <= '0;
			it_q        <= '0;
			conv_q      <= 1'b0;
			done_q      <= 1'b0;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			radius_q    <= 31'd65536;
			inside_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			if (cfg_we) begin
				case (cfg_addr)
					ssni_pkg::REG_CENTER_X:    center_q[0] <= cfg_wdata;
					ssni_pkg::REG_CENTER_Y:    center_q[1] <= cfg_wdata;
					ssni_pkg::REG_CENTER_Z:    center_q[2] <= cfg_wdata;
					ssni_pkg::REG_RADIUS:      radius_q    <= cfg_wdata[30:0];
					ssni_pkg::REG_INSIDE_MODE: inside_q    <= cfg_wdata[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
						ms_q    <= '0;
						it_q    <= '0;
						conv_q  <= 1'b0;
					end
				end
				S_EVAL: begin
					if (ms_q == 4'd5 && conv_now) begin
						conv_q  <= 1'b1;
						state_q <= S_FIN;
					end else if (ms_q == 4'd11) begin
						state_q <= S_NUM;
						ms_q    <= '0;
						coord_q <= '0;
					end else begin
						ms_q <= ms_q + 4'd1;
					end
				end
				S_NUM: begin
					if (div_req.go) begin
						state_q <= S_DIV;
					end else if (flat_fire) begin
						ms_q <= '0;
						if (!last_coord) begin
							coord_q <= coord_q + 2'd1;
						end else begin
							it_q    <= it_q + 7'd1;
							state_q <= last_iter ? S_FIN : S_EVAL;
						end
					end else begin
						ms_q <= ms_q + 4'd1;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						ms_q <= '0;
						if (!last_coord) begin
							coord_q <= coord_q + 2'd1;
							state_q <= S_NUM;
						end else begin
							it_q    <= it_q + 7'd1;
							state_q <= last_iter ? S_FIN : S_EVAL;
						end
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if (state_q == S_IDLE && start) begin
			p_q[0] <= 32'((33'(in_x) + 33'(out_x)) >>> 1);
			p_q[1] <= 32'((33'(in_y) + 33'(out_y)) >>> 1);
			p_q[2] <= 32'((33'(in_z) + 33'(out_z)) >>> 1);
			s_q[0] <= 33'(out_x) - 33'(in_x);
			s_q[1] <= 33'(out_y) - 33'(in_y);
			s_q[2] <= 33'(out_z) - 33'(in_z);
		end
		if (state_q == S_EVAL) begin
			case (ms_q)
				4'd1: val_q <= ssni_pkg::sat_prod(prod_s1);
				4'd2, 4'd3: val_q <= ssni_pkg::sat_add(val_q, ssni_pkg::sat_prod(prod_s1));
				4'd4: val_q <= inside_q ? ssni_pkg::sat_neg(val_rr) : val_rr;
				4'd5: dot_q <= ssni_pkg::sat_prod(prod_s1);
				4'd6, 4'd7: dot_q <= ssni_pkg::sat_add(dot_q, ssni_pkg::sat_prod(prod_s1));
				4'd8: dot_q <= inside_q ? ssni_pkg::sat_neg(dot_x2) : dot_x2;
				4'd10: wlo_q <= prod_s1[63:0];
				4'd11: flat_q <= flat_now;
				default: ;
			endcase
		end
		if (state_q == S_NUM && ms_q == 4'd1)
			nlo_q <= prod_s1[64:0];
		if (step_done)
			p_q[coord_q] <= p_new;
		if (state_q == S_FIN) begin
			hit_q[0]   <= p_q[0];
			hit_q[1]   <= p_q[1];
			hit_q[2]   <= p_q[2];
			conv_out_q <= conv_q;
			iter_out_q <= it_q;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign hit_x      = hit_q[0];
	assign hit_y      = hit_q[1];
	assign hit_z      = hit_q[2];
	assign converged  = conv_out_q;
	assign iterations = iter_out_q;

	`SSNI_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`SSNI_ASSERT_NOW(a_iter_range, clk, arst_n, done, iterations <= 7'(MAX_ITER))
	`SSNI_ASSERT_NOW(a_conv_early, clk, arst_n, done && converged, iterations < 7'(MAX_ITER))
	`SSNI_ASSERT_NOW(a_div_free, clk, arst_n, div_req.go, !div_stat.busy)

endmodule

`default_nettype wire

// ===== design/ssni_div_cell.sv =====
// ----------------------------------------------------------------------------
// ssni_div_cell
// One restoring division step: shift in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module ssni_div_cell (
	input  wire logic [ssni_pkg::DEN_W-1:0] rem_in,
	input  wire logic                       bit_in,
	input  wire logic [ssni_pkg::DEN_W-1:0] den,
	output logic      [ssni_pkg::DEN_W-1:0] rem_out,
	output logic                            q_out
);

	logic [ssni_pkg::DEN_W:0] shifted;
	logic [ssni_pkg::DEN_W:0] diff;

	always_comb begin
		shifted = {rem_in, bit_in};
		diff    = shifted - {1'b0, den};
		q_out   = (shifted >= {1'b0, den});
		rem_out = q_out ? diff[ssni_pkg::DEN_W-1:0] : shifted[ssni_pkg::DEN_W-1:0];
	end

endmodule

`default_nettype wire

// ===== design/ssni_div.sv =====
// ----------------------------------------------------------------------------
// ssni_div
// Divider built from a row of division cells; the remainder passes from
// cell to cell, and the row retires DIV_CELLS quotient bits per cycle while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module ssni_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ssni_pkg::div_req_t            req,
	output ssni_pkg::div_stat_t                stat,
	output logic      [ssni_pkg::NUM_W-1:0]    quo
);

	localparam int CELLS = ssni_pkg::DIV_CELLS;
	localparam int NW    = ssni_pkg::NUM_W;
	localparam int DW    = ssni_pkg::DEN_W;

	logic [NW-1:0]                    num_q;
	logic [NW-1:0]                    quo_q;
	logic [DW-1:0]                    rem_q;
	logic [DW-1:0]                    den_q;
	logic [ssni_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [DW-1:0]                    rem_c [CELLS+1];
	logic [CELLS-1:0]                 qb;

	assign rem_c[0] = rem_q;

	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		ssni_div_cell u_cell (
			.rem_in  (rem_c[j]),
			.bit_in  (num_q[NW-1-j]),
			.den     (den_q),
			.rem_out (rem_c[j+1]),
			.q_out   (qb[CELLS-1-j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.go
				&& (cnt_q == ssni_pkg::DIV_CNT_W'(ssni_pkg::DIV_STEPS - 1));
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ssni_pkg::DIV_CNT_W'(ssni_pkg::DIV_STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << CELLS;
			rem_q <= rem_c[CELLS];
			quo_q <= {quo_q[NW-1-CELLS:0], qb};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

`default_nettype wire
